>>> rtl/assert_macros.svh
// Assertion macros for the rate limiter controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, skipped while reset is high.
`define PSRL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("psrl assertion failed");
// Next-cycle implication, skipped while reset is high.
`define PSRL_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("psrl assertion failed");
`else
`define PSRL_ASSERT_IMP(label, clk, rst, ante, cons)
`define PSRL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/psrl_pkg.sv
// Types and constants shared by the rate limiter modules.
package psrl_pkg;

   localparam logic OP_ATTEMPT = 1'b0;
   localparam logic OP_SWEEP   = 1'b1;

   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_MAX    = 2'd1;
   localparam logic [1:0] CSR_STALE  = 2'd2;

   localparam logic [31:0] WINDOW_RESET = 32'd10000;
   localparam logic [7:0]  MAX_RESET    = 8'd5;
   localparam logic [31:0] STALE_RESET  = 32'd60000;

   localparam logic [7:0] COUNT_MAX = 8'hFF;
   localparam logic [6:0] FREED_MAX = 7'd127;

   typedef struct packed {
      logic        valid;
      logic [31:0] addr;
      logic [31:0] last_time;
      logic [7:0]  count;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic clear;
      logic start;
      logic read;
      logic update;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_idx;
   } status_type;

endpackage

>>> rtl/psrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/psrl_datapath.sv
// Datapath: entry table, scan trackers, config registers and result register.
module psrl_datapath import psrl_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        req_opcode,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_now_ms,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data,
   output logic        rsp_limited,
   output logic [7:0]  rsp_attempt_count,
   output logic        rsp_evicted,
   output logic [6:0]  rsp_freed_count
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ENTRY_W = $bits(entry_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   // config
   logic [31:0] window_ff, window_in;
   logic [7:0]  max_ff, max_in;
   logic [31:0] stale_ff, stale_in;

   // scan control
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] dat_idx_ff, dat_idx_in;

   // request
   logic        op_ff, op_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] now_ff, now_in;

   // trackers
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_last_ff, hit_last_in;
   logic [7:0]       hit_count_ff, hit_count_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             old_found_ff, old_found_in;
   logic [IDX_W-1:0] old_idx_ff, old_idx_in;
   logic [31:0]      old_age_ff, old_age_in;
   logic [6:0]       freed_ff, freed_in;

   // result and output
   logic       res_limited_ff, res_limited_in;
   logic [7:0] res_count_ff, res_count_in;
   logic       res_evicted_ff, res_evicted_in;
   logic [6:0] res_freed_ff, res_freed_in;
   logic       rsp_limited_ff, rsp_limited_in;
   logic [7:0] rsp_count_ff, rsp_count_in;
   logic       rsp_evicted_ff, rsp_evicted_in;
   logic [6:0] rsp_freed_ff, rsp_freed_in;

   // memory port
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   entry_type        ram_wr_entry;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type        rd_entry;

   logic [31:0] age;
   logic        stale_hit;
   logic [31:0] gap;
   logic        restart;
   logic [7:0]  inc_count;
   logic [7:0]  new_count;
   logic [IDX_W-1:0] new_slot;

   psrl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry  = ram_rd_data;
   assign age       = now_ff - rd_entry.last_time;
   assign stale_hit = rd_vld_ff && (op_ff == OP_SWEEP) && rd_entry.valid && (age > stale_ff);

   assign gap       = now_ff - hit_last_ff;
   assign restart   = gap > window_ff;
   assign inc_count = (hit_count_ff == COUNT_MAX) ? COUNT_MAX : hit_count_ff + 8'd1;
   assign new_count = restart ? 8'd1 : inc_count;
   assign new_slot  = hit_found_ff ? hit_idx_ff : (free_found_ff ? free_idx_ff : old_idx_ff);

   assign status.last_idx = (idx_ff == LAST_IDX);

   // config writes
   always_comb begin
      window_in = window_ff;
      max_in    = max_ff;
      stale_in  = stale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW: window_in = csr_wr_data;
            CSR_MAX:    max_in    = csr_wr_data[7:0];
            CSR_STALE:  stale_in  = csr_wr_data;
            default:    ;
         endcase
      end
   end

   // table write port
   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_entry = '0;
      if (cmd.clear) begin
         ram_wr_en = 1'b1;
      end else if (stale_hit) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = dat_idx_ff;
      end else if (cmd.update && (op_ff == OP_ATTEMPT)) begin
         ram_wr_en              = 1'b1;
         ram_wr_addr            = new_slot;
         ram_wr_entry.valid     = 1'b1;
         ram_wr_entry.addr      = addr_ff;
         ram_wr_entry.last_time = now_ff;
         ram_wr_entry.count     = hit_found_ff ? new_count : 8'd1;
      end
   end

   // scan and tracker next state
   always_comb begin
      idx_in        = idx_ff;
      rd_vld_in     = cmd.read;
      dat_idx_in    = idx_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_last_in   = hit_last_ff;
      hit_count_in  = hit_count_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_age_in    = old_age_ff;
      freed_in      = freed_ff;

      if (cmd.start) begin
         idx_in        = '0;
         op_in         = req_opcode;
         addr_in       = req_source_addr;
         now_in        = req_now_ms;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         old_found_in  = 1'b0;
         old_age_in    = '0;
         freed_in      = '0;
      end else if (cmd.clear || cmd.read) begin
         idx_in = status.last_idx ? '0 : idx_ff + 1'b1;
      end

      if (rd_vld_ff) begin
         if (rd_entry.valid) begin
            if (!hit_found_ff && (rd_entry.addr == addr_ff)) begin
               hit_found_in = 1'b1;
               hit_idx_in   = dat_idx_ff;
               hit_last_in  = rd_entry.last_time;
               hit_count_in = rd_entry.count;
            end
            if (!old_found_ff || (age > old_age_ff)) begin
               old_found_in = 1'b1;
               old_idx_in   = dat_idx_ff;
               old_age_in   = age;
            end
         end else if (!free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = dat_idx_ff;
         end
         if (stale_hit && (freed_ff != FREED_MAX)) begin
            freed_in = freed_ff + 7'd1;
         end
      end
   end

   // result and output register
   always_comb begin
      res_limited_in = res_limited_ff;
      res_count_in   = res_count_ff;
      res_evicted_in = res_evicted_ff;
      res_freed_in   = res_freed_ff;
      if (cmd.update) begin
         if (op_ff == OP_SWEEP) begin
            res_limited_in = 1'b0;
            res_count_in   = '0;
            res_evicted_in = 1'b0;
            res_freed_in   = freed_ff;
         end else begin
            res_limited_in = hit_found_ff && !restart && (inc_count > max_ff);
            res_count_in   = hit_found_ff ? new_count : 8'd1;
            res_evicted_in = !hit_found_ff && !free_found_ff;
            res_freed_in   = '0;
         end
      end
      rsp_limited_in = rsp_limited_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_freed_in   = rsp_freed_ff;
      if (cmd.load_out) begin
         rsp_limited_in = res_limited_ff;
         rsp_count_in   = res_count_ff;
         rsp_evicted_in = res_evicted_ff;
         rsp_freed_in   = res_freed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         max_ff    <= MAX_RESET;
         stale_ff  <= STALE_RESET;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         max_ff    <= max_in;
         stale_ff  <= stale_in;
         idx_ff    <= idx_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      dat_idx_ff     <= dat_idx_in;
      op_ff          <= op_in;
      addr_ff        <= addr_in;
      now_ff         <= now_in;
      hit_found_ff   <= hit_found_in;
      hit_idx_ff     <= hit_idx_in;
      hit_last_ff    <= hit_last_in;
      hit_count_ff   <= hit_count_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      old_found_ff   <= old_found_in;
      old_idx_ff     <= old_idx_in;
      old_age_ff     <= old_age_in;
      freed_ff       <= freed_in;
      res_limited_ff <= res_limited_in;
      res_count_ff   <= res_count_in;
      res_evicted_ff <= res_evicted_in;
      res_freed_ff   <= res_freed_in;
      rsp_limited_ff <= rsp_limited_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   assign rsp_limited       = rsp_limited_ff;
   assign rsp_attempt_count = rsp_count_ff;
   assign rsp_evicted       = rsp_evicted_ff;
   assign rsp_freed_count   = rsp_freed_ff;

endmodule

>>> rtl/psrl_ctrl.sv
// Controller state machine: clearing pass, table scan, update and result handoff.
`include "assert_macros.svh"
module psrl_ctrl import psrl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.last_idx) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.read = 1'b1;
            if (status.last_idx) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   `PSRL_ASSERT_NXT(a_hold_loads, clock, reset, (state_ff == ST_HOLD) && !rsp_valid_ff, rsp_valid_ff)
   `PSRL_ASSERT_NXT(a_accept_scans, clock, reset, req_valid && !req_stall, state_ff == ST_SCAN)
   `PSRL_ASSERT_NXT(a_scan_ends, clock, reset, (state_ff == ST_SCAN) && status.last_idx, state_ff == ST_DRAIN)
   `PSRL_ASSERT_IMP(a_load_free, clock, reset, cmd.load_out, !rsp_valid_ff || !rsp_stall)

endmodule

>>> rtl/per_source_connect_rate_limiter.sv
// Top level of the per-source connection rate limiter (fixed window per address).
// After reset a clearing pass invalidates every table entry; requests wait.
// Each request scans the table one entry per cycle through the RAM read port.
// A result passes through the scan, drain, update and hold states before it is loaded.
// A new request is not accepted until the previous result has been loaded.
module per_source_connect_rate_limiter import psrl_pkg::*; #(
   parameter int ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_now_ms,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_limited,
   output logic [7:0]  rsp_attempt_count,
   output logic        rsp_evicted,
   output logic [6:0]  rsp_freed_count,
   // config write port: 0 window_ms, 1 max_attempts, 2 stale_age_ms
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wr_data
);

   // The controller sequences the work; the datapath holds the entry table
   // (one RAM word per slot: valid, address, last-attempt time, count).
   //
   // Attempt: the scan finds the first matching address, the lowest free
   // slot and the slot with the largest age (lowest index on ties). The
   // update cycle then rewrites the hit slot, or installs the address in
   // the free slot, or evicts the oldest slot when the table is full.
   //
   // Sweep: stale entries are invalidated during the scan itself, in the cycle
   // after their read, while the freed count saturates at 127.
   //
   // The result sits in an output register; a new request is accepted as
   // soon as the result is loaded, even if the consumer is still stalling.

   cmd_type    cmd;
   status_type status;

   psrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   psrl_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_opcode        (req_opcode),
      .req_source_addr   (req_source_addr),
      .req_now_ms        (req_now_ms),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_limited       (rsp_limited),
      .rsp_attempt_count (rsp_attempt_count),
      .rsp_evicted       (rsp_evicted),
      .rsp_freed_count   (rsp_freed_count)
   );

endmodule

>>> verif/per_source_connect_rate_limiter_tb.sv
// Self-checking testbench for the per-source connection rate limiter: directed and random requests.
`timescale 1ns / 1ps

module per_source_connect_rate_limiter_tb import psrl_pkg::*; ();

   localparam int SLOTS        = 64;
   localparam int CYCLE_LIMIT  = 1_000_000;
   // Covers one request's full table scan plus the result hold.
   localparam int DRAIN_CYCLES = SLOTS + 8;
   localparam int POOL_SIZE    = 96;
   // Index 3 has no register behind it; writes there must be ignored.
   localparam logic [1:0] CSR_SPARE = 2'd3;

   // One result as the block reports it.
   typedef struct packed {
      logic       limited;
      logic [7:0] attempt_count;
      logic       evicted;
      logic [6:0] freed_count;
   } verdict_type;

   // Shadow of the source table plus the queue of verdicts still owed by the block.
   class rate_limit_board;
      logic [31:0] window_ms;
      logic [7:0]  max_attempts;
      logic [31:0] stale_age_ms;
      bit          slot_live  [SLOTS];
      logic [31:0] slot_addr  [SLOTS];
      logic [31:0] slot_time  [SLOTS];
      logic [7:0]  slot_count [SLOTS];
      verdict_type pending_verdicts [$];
      int          mismatches;

      function new();
         window_ms    = WINDOW_RESET;
         max_attempts = MAX_RESET;
         stale_age_ms = STALE_RESET;
         foreach (slot_live[i]) slot_live[i] = 1'b0;
         mismatches = 0;
      endfunction

      function void write_register(logic [1:0] index, logic [31:0] data);
         case (index)
            CSR_WINDOW: window_ms    = data;
            CSR_MAX:    max_attempts = data[7:0];
            CSR_STALE:  stale_age_ms = data;
            default: ;
         endcase
      endfunction

      function verdict_type predict_attempt(logic [31:0] addr, logic [31:0] now);
         int          i;
         int          hit;
         int          vacant;
         int          oldest;
         logic [31:0] age;
         logic [31:0] oldest_age;
         verdict_type v;
         hit        = -1;
         vacant     = -1;
         oldest     = -1;
         oldest_age = '0;
         v          = '0;
         v.attempt_count = 8'd1;
         for (i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
               age = now - slot_time[i];
               if (hit < 0 && slot_addr[i] == addr) hit = i;
               // strict compare keeps the lowest index on ties
               if (oldest < 0 || age > oldest_age) begin
                  oldest     = i;
                  oldest_age = age;
               end
            end else if (vacant < 0) begin
               vacant = i;
            end
         end
         if (hit >= 0) begin
            age = now - slot_time[hit];
            if (age > window_ms) begin
               slot_count[hit] = 8'd1;
            end else begin
               if (slot_count[hit] != COUNT_MAX) slot_count[hit] = slot_count[hit] + 8'd1;
               v.limited = (slot_count[hit] > max_attempts);
            end
            slot_time[hit]  = now;
            v.attempt_count = slot_count[hit];
         end else begin
            if (vacant < 0) begin
               vacant    = oldest;
               v.evicted = 1'b1;
            end
            slot_live[vacant]  = 1'b1;
            slot_addr[vacant]  = addr;
            slot_time[vacant]  = now;
            slot_count[vacant] = 8'd1;
         end
         return v;
      endfunction

      function verdict_type predict_sweep(logic [31:0] now);
         int          i;
         logic [31:0] age;
         verdict_type v;
         v = '0;
         for (i = 0; i < SLOTS; i++) begin
            if (slot_live[i]) begin
               age = now - slot_time[i];
               if (age > stale_age_ms) begin
                  slot_live[i] = 1'b0;
                  if (v.freed_count != FREED_MAX) v.freed_count = v.freed_count + 7'd1;
               end
            end
         end
         return v;
      endfunction

      function void log_request(logic op, logic [31:0] addr, logic [31:0] now);
         if (op == OP_SWEEP) pending_verdicts.push_back(predict_sweep(now));
         else pending_verdicts.push_back(predict_attempt(addr, now));
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            $error("result with no request outstanding: limited %0d count %0d evicted %0d freed %0d",
                   got.limited, got.attempt_count, got.evicted, got.freed_count);
            mismatches++;
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.limited !== want.limited) begin
            $error("limited: expected %0d, actual %0d", want.limited, got.limited);
            mismatches++;
         end
         if (got.attempt_count !== want.attempt_count) begin
            $error("attempt_count: expected %0d, actual %0d", want.attempt_count, got.attempt_count);
            mismatches++;
         end
         if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d, actual %0d", want.evicted, got.evicted);
            mismatches++;
         end
         if (got.freed_count !== want.freed_count) begin
            $error("freed_count: expected %0d, actual %0d", want.freed_count, got.freed_count);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [31:0] req_source_addr;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_limited;
   logic [7:0]  rsp_attempt_count;
   logic        rsp_evicted;
   logic [6:0]  rsp_freed_count;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wr_data;

   rate_limit_board board;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   logic [31:0] sim_ms;
   logic [31:0] addr_pool [POOL_SIZE];
   int unsigned cycle_count;

   per_source_connect_rate_limiter #(.ENTRIES(SLOTS)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_source_addr   (req_source_addr),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_limited       (rsp_limited),
      .rsp_attempt_count (rsp_attempt_count),
      .rsp_evicted       (rsp_evicted),
      .rsp_freed_count   (rsp_freed_count),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: stall pattern changes on the falling edge, independent of rsp_valid.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // A result is taken at the rising edge where valid is up and we are not stalling.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_verdict({rsp_limited, rsp_attempt_count, rsp_evicted, rsp_freed_count});
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance with valid
   // still high, so back-to-back requests never drop and raise valid in one step.
   task automatic drive_request(input logic op, input logic [31:0] addr, input logic [31:0] now);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_source_addr <= addr;
      req_now_ms      <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.log_request(op, addr, now);
      @(negedge clock);
   endtask

   // Drops the request line and waits until every owed verdict has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(negedge clock);
   endtask

   // Leaves the write enable high so consecutive writes need no toggle; configure lowers it.
   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      board.write_register(index, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] window, input logic [7:0] max_count,
                            input logic [31:0] stale_age);
      wait_drained();
      write_csr(CSR_WINDOW, window);
      write_csr(CSR_MAX, {24'd0, max_count});
      write_csr(CSR_STALE, stale_age);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly repeat visits from a pool of sources with small time steps, so windows,
   // saturation and evictions are reached; a share of fresh sources, sweeps and jumps.
   task automatic run_random(input int items, input int pool_span, input int unsigned step_max,
                             input int sweep_pct, input int fresh_pct);
      int          n;
      int unsigned pick;
      logic        op;
      logic [31:0] addr;
      for (n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) sim_ms = sim_ms + $urandom_range(3);
         else if (pick < 85) sim_ms = sim_ms + $urandom_range(step_max);
         else if (pick < 97) sim_ms = sim_ms + $urandom_range(step_max * 8);
         else sim_ms = $urandom();
         op = ($urandom_range(99) < sweep_pct) ? OP_SWEEP : OP_ATTEMPT;
         if ($urandom_range(99) < fresh_pct) addr = $urandom();
         else addr = addr_pool[$urandom_range(pool_span - 1)];
         drive_request(op, addr, sim_ms);
      end
   endtask

   initial begin
      board           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_opcode      = OP_ATTEMPT;
      req_source_addr = '0;
      req_now_ms      = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_WINDOW;
      csr_wr_data     = '0;
      addr_pool[0]    = 32'h0000_0000;
      addr_pool[1]    = 32'hFFFF_FFFF;
      for (int k = 2; k < POOL_SIZE; k++) addr_pool[k] = $urandom();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // ---- Directed: short window so each edge case lands on an exact gap ----
      write_csr(CSR_SPARE, 32'hDEAD_BEEF);
      configure(32'd100, 8'd2, 32'd500);
      drive_request(OP_ATTEMPT, 32'h0000_0000, 32'd1000);       // unknown source
      drive_request(OP_ATTEMPT, 32'h0000_0000, 32'd1100);       // gap equal to window
      drive_request(OP_ATTEMPT, 32'h0000_0000, 32'd1150);       // over max: limited
      drive_request(OP_ATTEMPT, 32'h0000_0000, 32'd1251);       // gap past window: restart
      drive_request(OP_ATTEMPT, 32'hFFFF_FFFF, 32'd1251);
      drive_request(OP_SWEEP,   32'hFFFF_FFFF, 32'd1751);       // age equal to stale: kept
      drive_request(OP_SWEEP,   32'h0000_0000, 32'd1752);       // one past: freed
      drive_request(OP_ATTEMPT, 32'h1234_5678, 32'hFFFF_FFF0);
      drive_request(OP_ATTEMPT, 32'h1234_5678, 32'h0000_0010);  // gap across the wrap
      drive_request(OP_ATTEMPT, 32'h1234_5678, 32'h0000_0050);
      configure(32'd100, 8'd1, 32'd500);
      drive_request(OP_ATTEMPT, 32'h1234_5678, 32'h0000_0060);
      drive_request(OP_ATTEMPT, 32'h8000_0001, 32'h0000_0060);  // new source never limited
      drive_request(OP_ATTEMPT, 32'h8000_0001, 32'h0000_0061);
      configure(32'hFFFF_FFFF, 8'd254, 32'hFFFF_FFFF);
      drive_request(OP_ATTEMPT, 32'h8000_0001, 32'h8000_0061);  // half-range gap, still inside
      drive_request(OP_SWEEP,   32'h5555_AAAA, 32'h0000_005F);  // near-max age, nothing stale
      configure(32'd1, 8'd1, 32'd1);
      drive_request(OP_ATTEMPT, 32'h8000_0001, 32'h8000_0062);  // gap 1 with window 1
      drive_request(OP_ATTEMPT, 32'h8000_0001, 32'h8000_0064);  // gap 2: restart
      drive_request(OP_SWEEP,   32'hAAAA_5555, 32'h8000_0065);  // frees the old entry only

      sim_ms = 32'h8000_0100;

      // ---- Random phases; idling mode changes every two phases ----
      // One hot source, endless window: the count climbs to saturation.
      send_idle_pct = 0;  stall_pct = 0;
      configure(32'hFFFF_FFFF, 8'd254, 32'hFFFF_FFFF);
      run_random(320, 1, 5, 2, 5);
      // More sources than slots: table fills and evicts.
      configure(32'd40, 8'd3, 32'd400);
      run_random(130, POOL_SIZE, 30, 8, 10);

      send_idle_pct = 86; stall_pct = 0;
      configure(32'd1, 8'd1, 32'd1);
      run_random(130, 40, 3, 10, 5);
      configure(WINDOW_RESET, MAX_RESET, STALE_RESET);
      run_random(130, POOL_SIZE, 4000, 6, 10);

      send_idle_pct = 0;  stall_pct = 86;
      configure($urandom_range(2000, 10), 8'($urandom_range(254, 1)),
                $urandom_range(20000, 100));
      run_random(130, POOL_SIZE, 500, 8, 10);
      configure($urandom(), 8'($urandom_range(254, 1)), $urandom());
      run_random(130, 70, 32'h0100_0000, 8, 15);

      send_idle_pct = 31; stall_pct = 31;
      configure(32'd200, 8'd254, 32'd1000);
      run_random(130, 40, 60, 8, 5);
      configure(32'd200, 8'd2, 32'd3000);
      run_random(130, POOL_SIZE, 100, 8, 10);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.mismatches == 0 && board.pending_verdicts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
